// File: design/hra_pkg.sv
package hra_pkg;

	// Table geometry
	localparam int ROW_COUNT        = 14;
	localparam int ROW_W            = 4;
	localparam int LOWEST_ELEVATION = -40;
	localparam int ELEVATION_STEP   = 10;
	localparam int STEP_USED        = (ELEVATION_STEP < 1) ? 1 : ELEVATION_STEP;
	localparam int RECORD_WORDS     = 256;
	localparam int FULL_TURN        = 360;
	localparam int HALF_TURN        = 180;

	// Field widths
	localparam int ELEV_NUM_W = 19;
	localparam int COL_W      = 6;
	localparam int REC_W      = 9;
	localparam int OFS_W      = 17;
	localparam int RW_W       = $clog2(RECORD_WORDS + 1);
	localparam int OFS_PROD_W = REC_W + RW_W;

	// Azimuth reduction: floor(mag / 360) as (mag * AZ_RECIP) >> AZ_SHIFT, exact for 16 bits
	localparam int AZ_SHIFT  = 25;
	localparam int AZ_RECIP  = ((2 ** AZ_SHIFT) + FULL_TURN - 1) / FULL_TURN;
	localparam int AZ_PROD_W = 16 + 17;

	// Column rounding: floor((2*az*cnt + 360) / 720) folded into one product per row
	localparam int COL_SHIFT  = 24;
	localparam int COL_RECIP  = ((2 ** COL_SHIFT) + 2 * FULL_TURN - 1) / (2 * FULL_TURN);
	localparam int COL_BIAS   = FULL_TURN * COL_RECIP;
	localparam int COL_PROD_W = COL_SHIFT + COL_W;
	localparam int SCALE_W    = 22;

	typedef logic [6:0]         pos_tab_t   [ROW_COUNT];
	typedef logic [REC_W-1:0]   base_tab_t  [ROW_COUNT];
	typedef logic [SCALE_W-1:0] scale_tab_t [ROW_COUNT];

	localparam pos_tab_t ROW_POSITIONS = '{
		7'd56, 7'd60, 7'd72, 7'd72, 7'd72, 7'd72, 7'd72,
		7'd60, 7'd56, 7'd45, 7'd36, 7'd24, 7'd12, 7'd1
	};

	// First record of each row: running sum of stored half-circle positions
	function automatic base_tab_t build_base();
		base_tab_t  tab;
		logic [REC_W-1:0] acc;
		acc = '0;
		for (int r = 0; r < ROW_COUNT; r++) begin
			tab[r] = acc;
			acc = acc + REC_W'(ROW_POSITIONS[r] / 2 + 1);
		end
		return tab;
	endfunction

	// Per-row multiplier for the column rounding
	function automatic scale_tab_t build_scale();
		scale_tab_t tab;
		for (int r = 0; r < ROW_COUNT; r++)
			tab[r] = SCALE_W'(2 * int'(ROW_POSITIONS[r]) * COL_RECIP);
		return tab;
	endfunction

	localparam base_tab_t  ROW_BASE  = build_base();
	localparam scale_tab_t ROW_SCALE = build_scale();

	// Folded azimuth between the reduction unit and the pipeline
	typedef struct packed {
		logic [7:0] angle;
		logic       swap;
	} fold_t;

endpackage

// File: design/hra_azim_fold.sv
module hra_azim_fold (
	input  logic signed [15:0] azimuth,
	output hra_pkg::fold_t     fold
);

	logic [15:0]                  mag;
	logic [hra_pkg::AZ_PROD_W-1:0] prod;
	logic [6:0]                   quot;
	logic [15:0]                  rem_full;
	logic [8:0]                   rem;
	logic [8:0]                   pos;

	// Magnitude, quotient by reciprocal, remainder by constant multiply-subtract
	always_comb begin
		mag      = azimuth[15] ? (~azimuth + 16'd1) : azimuth;
		prod     = hra_pkg::AZ_PROD_W'(mag) * hra_pkg::AZ_PROD_W'(hra_pkg::AZ_RECIP);
		quot     = prod[hra_pkg::AZ_SHIFT +: 7];
		rem_full = mag - 16'(quot * 16'(hra_pkg::FULL_TURN));
		rem      = rem_full[8:0];
	end

	// Make non-negative, then mirror the right half
	always_comb begin
		if (azimuth[15] && (rem != 9'd0))
			pos = 9'(hra_pkg::FULL_TURN) - rem;
		else
			pos = rem;
		if (pos > 9'(hra_pkg::HALF_TURN)) begin
			fold.angle = 8'(9'(hra_pkg::FULL_TURN) - pos);
			fold.swap  = 1'b1;
		end else begin
			fold.angle = pos[7:0];
			fold.swap  = 1'b0;
		end
	end

endmodule

// File: design/hrtf_record_address_top.sv
// Channel  | Direction | Handshake          | Payload
// s        | in        | s_tvalid/s_tready  | tdata: elevation_deg, azimuth_deg
// m        | out       | m_tvalid/m_tready  | tdata: indices, record, offset; tuser: swap
//
// Three register stages: input, folded angles with elevation row, result.
// One transaction per cycle sustained while m_tready is high; m_tvalid rises when the result register loads.
// Each stage loads when it is empty or the stage after it moves, so bubbles close up
// under a stalled output and input is still taken while a result waits.
// arst_n clears the valid flags only; the data registers are not reset.
module hrtf_record_address_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [15:0] elevation_deg, [31:16] azimuth_deg
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [3:0] elevation_index, [9:4] azimuth_index,
	                               // [18:10] record_number, [35:19] word_offset, rest zero
	output logic [0:0]  m_tuser    // [0] swap_channels
);

	logic                       v_s1, v_s2, out_v_q;
	logic                       rdy_out, rdy_s2, rdy_s1;
	logic signed [15:0]         elev_s1, azim_s1;
	logic [hra_pkg::ROW_W-1:0]  row_s2;
	hra_pkg::fold_t             fold_s2;
	hra_pkg::fold_t             fold;
	logic signed [hra_pkg::ELEV_NUM_W-1:0] elev_diff, elev_num;
	logic [hra_pkg::ROW_W-1:0]  row;
	logic [hra_pkg::COL_PROD_W-1:0] col_prod;
	logic [hra_pkg::COL_W-1:0]  col_raw, col_lim, col;
	logic [hra_pkg::REC_W-1:0]  record;
	logic [hra_pkg::OFS_PROD_W-1:0] ofs_prod;
	logic [hra_pkg::ROW_W-1:0]  row_q;
	logic [hra_pkg::COL_W-1:0]  col_q;
	logic                       swap_q;
	logic [hra_pkg::REC_W-1:0]  record_q;
	logic [hra_pkg::OFS_W-1:0]  ofs_q;

	// Stage readiness, back to front
	assign rdy_out  = !out_v_q || m_tready;
	assign rdy_s2   = !v_s2 || rdy_out;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign s_tready = rdy_s1;

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (rdy_s1)
				v_s1 <= s_tvalid;
			if (rdy_s2)
				v_s2 <= v_s1;
			if (rdy_out)
				out_v_q <= v_s2;
		end
	end

	// Capture the input transaction
	always_ff @(posedge clk) begin
		if (rdy_s1 && s_tvalid) begin
			elev_s1 <= s_tdata[15:0];
			azim_s1 <= s_tdata[31:16];
		end
	end

	// Elevation row: half-up rounding by threshold count, clipped at both ends
	always_comb begin
		elev_diff = hra_pkg::ELEV_NUM_W'(elev_s1)
			- hra_pkg::ELEV_NUM_W'(hra_pkg::LOWEST_ELEVATION);
		elev_num  = (elev_diff <<< 1) + hra_pkg::ELEV_NUM_W'(hra_pkg::STEP_USED);
		row = '0;
		for (int k = 1; k < hra_pkg::ROW_COUNT; k++) begin
			if (elev_num >= signed'(hra_pkg::ELEV_NUM_W'(2 * k * hra_pkg::STEP_USED)))
				row = row + 1'b1;
		end
	end

	hra_azim_fold u_fold (
		.azimuth (azim_s1),
		.fold    (fold)
	);

	// Hold row and folded azimuth
	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			row_s2  <= row;
			fold_s2 <= fold;
		end
	end

	// Column, record number and word offset
	always_comb begin
		col_prod = hra_pkg::COL_PROD_W'(fold_s2.angle)
			* hra_pkg::COL_PROD_W'(hra_pkg::ROW_SCALE[row_s2])
			+ hra_pkg::COL_PROD_W'(hra_pkg::COL_BIAS);
		col_raw  = col_prod[hra_pkg::COL_SHIFT +: hra_pkg::COL_W];
		col_lim  = hra_pkg::COL_W'(hra_pkg::ROW_POSITIONS[row_s2] >> 1);
		col      = (col_raw > col_lim) ? col_lim : col_raw;
		record   = hra_pkg::ROW_BASE[row_s2] + hra_pkg::REC_W'(col);
		ofs_prod = hra_pkg::OFS_PROD_W'(record)
			* hra_pkg::OFS_PROD_W'(hra_pkg::RECORD_WORDS);
	end

	// Result register
	always_ff @(posedge clk) begin
		if (rdy_out && v_s2) begin
			row_q    <= row_s2;
			col_q    <= col;
			swap_q   <= fold_s2.swap;
			record_q <= record;
			ofs_q    <= ofs_prod[hra_pkg::OFS_W-1:0];
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {4'd0, ofs_q, record_q, col_q, row_q};
	assign m_tuser  = swap_q;

	// Result fields agree with each other; the input is ready whenever the first stage is empty
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> (row_q < hra_pkg::ROW_W'(hra_pkg::ROW_COUNT)))
		else $error("elevation row out of table");

	a_col_clip: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> (col_q <= hra_pkg::COL_W'(hra_pkg::ROW_POSITIONS[row_q] >> 1)))
		else $error("azimuth index past stored positions");

	a_record_sum: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> (record_q == hra_pkg::ROW_BASE[row_q] + hra_pkg::REC_W'(col_q)))
		else $error("record number does not match row base plus column");

	a_ofs_scale: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> (ofs_q == hra_pkg::OFS_W'(hra_pkg::OFS_PROD_W'(record_q)
			* hra_pkg::OFS_PROD_W'(hra_pkg::RECORD_WORDS))))
		else $error("word offset does not match record number");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s1 |-> s_tready)
		else $error("input stalled with empty first stage");

endmodule
